/* sv/fpcs_pkg.sv */
// Shared types, codes and rule arithmetic for the four-point curve subdivider.
package fpcs_pkg;

	localparam int ADDR_W  = 7;
	localparam int LVL_W   = 3;
	localparam int CNT_W   = 6;
	localparam int MAX_OUT = 33;

	localparam logic [2:0] ACT_LOAD    = 3'd0;
	localparam logic [2:0] ACT_OPEN    = 3'd1;
	localparam logic [2:0] ACT_SIX     = 3'd2;
	localparam logic [2:0] ACT_ADV     = 3'd3;
	localparam logic [2:0] ACT_ADV_END = 3'd4;

	localparam logic [2:0] SRC_RD   = 3'd0;
	localparam logic [2:0] SRC_LOOK = 3'd1;
	localparam logic [2:0] SRC_STG0 = 3'd2;
	localparam logic [2:0] SRC_STG1 = 3'd3;
	localparam logic [2:0] SRC_STG2 = 3'd4;
	localparam logic [2:0] SRC_STG3 = 3'd5;
	localparam logic [2:0] SRC_STG4 = 3'd6;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pt_t;

	typedef struct packed {
		logic [32:0] s;
		logic [34:0] t;
	} pre_t;

	typedef struct packed {
		logic                          rule;
		logic                          brk;
		logic                          more;
		logic [3:0][2:0]               src;
		logic [3:0][ADDR_W-1:0]        addr;
		logic [ADDR_W-1:0]             waddr;
	} uop_t;

	typedef struct packed {
		logic              accept;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              cap_en;
		logic [1:0]        cap_idx;
		logic [2:0]        cap_src;
		logic              rule_s1;
		logic              rule_s2;
		logic              wr_en;
		logic              wr_rule;
		logic [ADDR_W-1:0] wr_addr;
		logic              look_ld;
		logic              fn_clr;
		logic              fn_prev;
		logic              fn_dist;
		logic              fn_max;
		logic              out_ld;
		logic              out_final;
	} dp_cmd_t;

	typedef struct packed {
		logic fn_ge;
		logic out_free;
	} dp_stat_t;

	// s = b+c, t = s-a-d, exact
	function automatic pre_t rule_pre(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		pre_t p;
		p.s = {b[31], b} + {c[31], c};
		p.t = {{2{p.s[32]}}, p.s} - {{3{a[31]}}, a} - {{3{d[31]}}, d};
		return p;
	endfunction

	// s/2 + t/16 truncating toward zero, saturated to 32 bits
	function automatic logic [31:0] rule_fin(input pre_t p);
		logic [32:0] sb;
		logic [34:0] tb;
		logic [35:0] r;
		sb = p.s + {32'd0, p.s[32]};
		tb = p.t + (p.t[34] ? 35'd15 : 35'd0);
		r  = {{4{sb[32]}}, sb[32:1]} + {{5{tb[34]}}, tb[34:4]};
		if (r[35:31] == 5'b00000 || r[35:31] == 5'b11111) begin
			return r[31:0];
		end
		return r[35] ? 32'h8000_0000 : 32'h7fff_ffff;
	endfunction

endpackage

/* sv/fpcs_datapath.sv */
// Datapath: point buffer memory, operand registers, rule unit, step scan and output register.
module fpcs_datapath #(
	parameter int SEGMENT_SPAN  = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fpcs_pkg::dp_cmd_t      cmd,
	output fpcs_pkg::dp_stat_t     stat,
	input  logic [2:0]             action,
	input  logic signed [31:0]     point_x,
	input  logic signed [31:0]     point_y,
	input  logic                   cfg_write_en,
	input  logic [30:0]            cfg_write_data,
	output logic                   curve_valid,
	input  logic                   curve_stall,
	output logic signed [31:0]     curve_x,
	output logic signed [31:0]     curve_y,
	output logic                   final_point
);
	import fpcs_pkg::*;

	localparam int BUF_DEPTH = 3 * SEGMENT_SPAN + 1;
	localparam int MW        = $clog2(BUF_DEPTH);

	pt_t        mem [BUF_DEPTH];
	pt_t        mem_q;
	logic       oob_q;
	pt_t        rd_pt;
	pt_t        stg_q [5];
	pt_t        look_q;
	pt_t        inp_q;
	pt_t        opnd_q [4];
	pre_t       pre_x_s1;
	pre_t       pre_y_s1;
	pt_t        res_q;
	pt_t        prev_q;
	logic [31:0] dist_q;
	logic [31:0] max_q;
	logic [30:0] limit_q;
	logic       curve_valid_q;
	pt_t        out_q;
	logic       final_q;
	pt_t        cap_pt;
	pt_t        wr_pt;

	function automatic logic [31:0] step_dist(input pt_t a, input pt_t b);
		logic [32:0] dx;
		logic [32:0] dy;
		logic [32:0] m;
		dx = {a.x[31], a.x} - {b.x[31], b.x};
		dy = {a.y[31], a.y} - {b.y[31], b.y};
		dx = dx[32] ? (33'd0 - dx) : dx;
		dy = dy[32] ? (33'd0 - dy) : dy;
		m  = (dx > dy) ? dx : dy;
		m  = m >> FRACTION_BITS;
		return m[31:0];
	endfunction

	assign rd_pt = oob_q ? '0 : mem_q;
	assign wr_pt = cmd.wr_rule ? res_q : opnd_q[0];

	always_comb begin
		case (cmd.cap_src)
			SRC_RD:   cap_pt = rd_pt;
			SRC_LOOK: cap_pt = look_q;
			SRC_STG0: cap_pt = stg_q[0];
			SRC_STG1: cap_pt = stg_q[1];
			SRC_STG2: cap_pt = stg_q[2];
			SRC_STG3: cap_pt = stg_q[3];
			SRC_STG4: cap_pt = stg_q[4];
			default:  cap_pt = '0;
		endcase
	end

	// buffer memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_addr < ADDR_W'(BUF_DEPTH)) begin
			mem[cmd.wr_addr[MW-1:0]] <= wr_pt;
		end
		if (cmd.rd_en) begin
			mem_q <= mem[cmd.rd_addr[MW-1:0]];
			oob_q <= cmd.rd_addr >= ADDR_W'(BUF_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q        <= '0;
			limit_q       <= 31'd1;
			curve_valid_q <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
			if (cmd.accept && (action == ACT_OPEN || action == ACT_SIX)) begin
				look_q <= '{x: point_x, y: point_y};
			end else if (cmd.look_ld) begin
				look_q <= inp_q;
			end
			if (cmd.out_ld) begin
				curve_valid_q <= 1'b1;
			end else if (!curve_stall) begin
				curve_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			inp_q <= '{x: point_x, y: point_y};
			if (action == ACT_LOAD) begin
				for (int n = 0; n < 4; n++) begin
					stg_q[n] <= stg_q[n+1];
				end
				stg_q[4] <= '{x: point_x, y: point_y};
			end
		end
		if (cmd.cap_en) begin
			opnd_q[cmd.cap_idx] <= cap_pt;
		end
		if (cmd.rule_s1) begin
			pre_x_s1 <= rule_pre(opnd_q[0].x, opnd_q[1].x, opnd_q[2].x, opnd_q[3].x);
			pre_y_s1 <= rule_pre(opnd_q[0].y, opnd_q[1].y, opnd_q[2].y, opnd_q[3].y);
		end
		if (cmd.rule_s2) begin
			res_q.x <= rule_fin(pre_x_s1);
			res_q.y <= rule_fin(pre_y_s1);
		end
		if (cmd.fn_clr) begin
			max_q <= '0;
		end else if (cmd.fn_max && dist_q > max_q) begin
			max_q <= dist_q;
		end
		if (cmd.fn_prev || cmd.fn_dist) begin
			prev_q <= rd_pt;
		end
		if (cmd.fn_dist) begin
			dist_q <= step_dist(prev_q, rd_pt);
		end
		if (cmd.out_ld) begin
			out_q   <= rd_pt;
			final_q <= cmd.out_final;
		end
	end

	assign stat.fn_ge    = max_q >= {1'b0, limit_q};
	assign stat.out_free = !curve_valid_q || !curve_stall;

	assign curve_valid = curve_valid_q;
	assign curve_x     = out_q.x;
	assign curve_y     = out_q.y;
	assign final_point = final_q;

endmodule

/* sv/fpcs_ctrl.sv */
// Controller: request intake, setup micro-ops, refinement loop, step scan and emit sequencing.
module fpcs_ctrl #(
	parameter int MAX_LEVEL    = 5,
	parameter int SEGMENT_SPAN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	output logic                point_stall,
	input  logic [2:0]          action,
	output fpcs_pkg::dp_cmd_t   cmd,
	input  fpcs_pkg::dp_stat_t  stat
);
	import fpcs_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_G_ISS  = 5'd1;
	localparam logic [4:0] S_G_CAP  = 5'd2;
	localparam logic [4:0] S_R1     = 5'd3;
	localparam logic [4:0] S_R2     = 5'd4;
	localparam logic [4:0] S_WR     = 5'd5;
	localparam logic [4:0] S_RF_CHK = 5'd6;
	localparam logic [4:0] S_FN_RD0 = 5'd7;
	localparam logic [4:0] S_FN_C0  = 5'd8;
	localparam logic [4:0] S_FN_RD  = 5'd9;
	localparam logic [4:0] S_FN_C   = 5'd10;
	localparam logic [4:0] S_FN_M   = 5'd11;
	localparam logic [4:0] S_FN_END = 5'd12;
	localparam logic [4:0] S_RF_NXT = 5'd13;
	localparam logic [4:0] S_RF_DON = 5'd14;
	localparam logic [4:0] S_EM_RD  = 5'd15;
	localparam logic [4:0] S_EM_CAP = 5'd16;

	localparam logic [ADDR_W-1:0] A_0    = '0;
	localparam logic [ADDR_W-1:0] A_L    = ADDR_W'(SEGMENT_SPAN);
	localparam logic [ADDR_W-1:0] A_2L   = ADDR_W'(2 * SEGMENT_SPAN);
	localparam logic [ADDR_W-1:0] A_3L   = ADDR_W'(3 * SEGMENT_SPAN);
	localparam logic [ADDR_W-1:0] A_H    = ADDR_W'(SEGMENT_SPAN / 2);
	localparam logic [ADDR_W-1:0] A_HL   = ADDR_W'(SEGMENT_SPAN / 2 + SEGMENT_SPAN);
	localparam logic [ADDR_W-1:0] A_H2L  = ADDR_W'(SEGMENT_SPAN / 2 + 2 * SEGMENT_SPAN);
	localparam logic [ADDR_W-1:0] LEN1_0 = ADDR_W'(SEGMENT_SPAN / 4);
	localparam logic [ADDR_W-1:0] LEN2_0 = ADDR_W'(3 * (SEGMENT_SPAN / 4));
	localparam logic [ADDR_W-1:0] DLT_0  = ADDR_W'(2 * (SEGMENT_SPAN / 4));

	logic [4:0]        state_q;
	logic [2:0]        act_q;
	logic [3:0]        step_q;
	logic [1:0]        k_q;
	logic              in_ref_q;
	logic              more_q;
	logic [LVL_W-1:0]  level_q;
	logic [LVL_W-1:0]  refine_level_q;
	logic [ADDR_W-1:0] len1_q;
	logic [ADDR_W-1:0] len2_q;
	logic [ADDR_W-1:0] delta_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] em_i_q;
	logic [CNT_W-1:0]  n_q;
	uop_t              op;
	logic              accept;
	logic              last_k;
	logic              em_final;
	logic [ADDR_W-1:0] s_lvl;
	logic [ADDR_W-1:0] s_em;
	logic [ADDR_W-1:0] i_nxt;

	function automatic logic [ADDR_W-1:0] spacing(input logic [LVL_W-1:0] lv);
		logic [ADDR_W-1:0] s;
		s = A_L >> lv;
		return (s == '0) ? ADDR_W'(1) : s;
	endfunction

	function automatic uop_t mk_copy(input logic [2:0] src, input logic [ADDR_W-1:0] ra,
			input logic [ADDR_W-1:0] wa);
		uop_t u;
		u         = '0;
		u.src[0]  = src;
		u.addr[0] = ra;
		u.waddr   = wa;
		return u;
	endfunction

	// operands listed a,b,c,d
	function automatic uop_t mk_rule(input logic [2:0] sa, input logic [2:0] sb,
			input logic [2:0] sc, input logic [2:0] sd, input logic [ADDR_W-1:0] wa);
		uop_t u;
		u       = '0;
		u.rule  = 1'b1;
		u.src   = {sd, sc, sb, sa};
		u.waddr = wa;
		return u;
	endfunction

	assign accept      = point_valid && !point_stall;
	assign point_stall = state_q != S_IDLE;
	assign s_lvl       = spacing(level_q);
	assign s_em        = spacing(refine_level_q);
	assign i_nxt       = i_q + delta_q;
	assign em_final    = (em_i_q + s_em > A_2L) || (n_q == CNT_W'(MAX_OUT - 1));

	always_comb begin
		op = '0;
		if (in_ref_q) begin
			op.rule  = 1'b1;
			op.src   = {SRC_RD, SRC_RD, SRC_RD, SRC_RD};
			op.addr  = {i_q + len2_q, i_q + len1_q, i_q - len1_q, i_q - len2_q};
			op.waddr = i_q;
		end else if (act_q == ACT_OPEN) begin
			case (step_q)
				4'd0: op = mk_copy(SRC_STG2, A_0, A_0);
				4'd1: op = mk_copy(SRC_STG2, A_0, A_L);
				4'd2: op = mk_copy(SRC_STG3, A_0, A_2L);
				4'd3: op = mk_copy(SRC_STG4, A_0, A_3L);
				4'd4: op = mk_rule(SRC_STG2, SRC_STG2, SRC_STG3, SRC_STG4, A_H);
				4'd5: op = mk_rule(SRC_STG2, SRC_STG2, SRC_STG3, SRC_STG4, A_HL);
				4'd6: begin
					op      = mk_rule(SRC_STG2, SRC_STG3, SRC_STG4, SRC_LOOK, A_H2L);
					op.brk  = 1'b1;
					op.more = 1'b1;
				end
				4'd7: op = mk_rule(SRC_STG2, SRC_STG2, SRC_STG2, SRC_STG3, A_H);
				4'd8: op = mk_rule(SRC_STG2, SRC_STG2, SRC_STG3, SRC_STG4, A_HL);
				default: begin
					op     = mk_rule(SRC_STG2, SRC_STG3, SRC_STG4, SRC_LOOK, A_H2L);
					op.brk = 1'b1;
				end
			endcase
		end else if (act_q == ACT_SIX) begin
			case (step_q)
				4'd0: op = mk_copy(SRC_STG1, A_0, A_0);
				4'd1: op = mk_copy(SRC_STG2, A_0, A_L);
				4'd2: op = mk_copy(SRC_STG3, A_0, A_2L);
				4'd3: op = mk_copy(SRC_STG4, A_0, A_3L);
				4'd4: op = mk_rule(SRC_STG0, SRC_STG1, SRC_STG2, SRC_STG3, A_H);
				4'd5: op = mk_rule(SRC_STG1, SRC_STG2, SRC_STG3, SRC_STG4, A_HL);
				default: begin
					op     = mk_rule(SRC_STG2, SRC_STG3, SRC_STG4, SRC_LOOK, A_H2L);
					op.brk = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				4'd0: op = mk_copy(SRC_RD, A_L, A_0);
				4'd1: op = mk_copy(SRC_RD, A_2L, A_L);
				4'd2: op = mk_copy(SRC_RD, A_3L, A_2L);
				4'd3: op = mk_copy(SRC_LOOK, A_0, A_3L);
				4'd4: op = mk_copy(SRC_RD, A_HL, A_H);
				4'd5: op = mk_copy(SRC_RD, A_H2L, A_HL);
				default: begin
					op      = mk_rule(SRC_RD, SRC_RD, SRC_RD, SRC_LOOK, A_H2L);
					op.addr = {A_0, A_3L, A_2L, A_L};
					op.brk  = 1'b1;
				end
			endcase
		end
	end

	assign last_k = op.rule ? (k_q == 2'd3) : (k_q == 2'd0);

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.cap_idx   = k_q;
		cmd.cap_src   = op.src[k_q];
		cmd.wr_rule   = op.rule;
		cmd.wr_addr   = op.waddr;
		cmd.out_final = em_final;
		case (state_q)
			S_G_ISS: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = op.addr[k_q];
			end
			S_G_CAP:  cmd.cap_en  = 1'b1;
			S_R1:     cmd.rule_s1 = 1'b1;
			S_R2:     cmd.rule_s2 = 1'b1;
			S_WR: begin
				cmd.wr_en   = 1'b1;
				// advance with point: old lookahead went to the buffer, new one enters
				cmd.look_ld = !in_ref_q && act_q == ACT_ADV && step_q == 4'd3;
			end
			S_FN_RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = A_L;
				cmd.fn_clr  = 1'b1;
			end
			S_FN_C0:  cmd.fn_prev = 1'b1;
			S_FN_RD: begin
				cmd.rd_en   = j_q <= A_2L;
				cmd.rd_addr = j_q;
			end
			S_FN_C:   cmd.fn_dist = 1'b1;
			S_FN_M:   cmd.fn_max  = 1'b1;
			S_EM_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = em_i_q;
			end
			S_EM_CAP: cmd.out_ld = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			act_q          <= ACT_LOAD;
			step_q         <= '0;
			k_q            <= '0;
			in_ref_q       <= 1'b0;
			more_q         <= 1'b0;
			level_q        <= LVL_W'(1);
			refine_level_q <= LVL_W'(1);
			len1_q         <= '0;
			len2_q         <= '0;
			delta_q        <= '0;
			i_q            <= '0;
			j_q            <= '0;
			em_i_q         <= '0;
			n_q            <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && action inside {[ACT_OPEN:ACT_ADV_END]}) begin
						act_q    <= action;
						step_q   <= '0;
						k_q      <= '0;
						in_ref_q <= 1'b0;
						state_q  <= S_G_ISS;
					end
				end
				S_G_ISS: state_q <= S_G_CAP;
				S_G_CAP: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= op.rule ? S_R1 : S_WR;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_G_ISS;
					end
				end
				S_R1: state_q <= S_R2;
				S_R2: state_q <= S_WR;
				S_WR: begin
					if (in_ref_q) begin
						i_q     <= i_nxt;
						state_q <= (i_nxt <= A_2L + len1_q) ? S_G_ISS : S_RF_NXT;
					end else begin
						step_q <= step_q + 4'd1;
						if (op.brk) begin
							more_q  <= op.more;
							level_q <= LVL_W'(1);
							len1_q  <= LEN1_0;
							len2_q  <= LEN2_0;
							delta_q <= DLT_0;
							state_q <= S_RF_CHK;
						end else begin
							state_q <= S_G_ISS;
						end
					end
				end
				S_RF_CHK: begin
					if (level_q < LVL_W'(MAX_LEVEL) && len1_q != '0 && delta_q != '0) begin
						state_q <= S_FN_RD0;
					end else begin
						state_q <= S_RF_DON;
					end
				end
				S_FN_RD0: state_q <= S_FN_C0;
				S_FN_C0: begin
					j_q     <= A_L + s_lvl;
					state_q <= S_FN_RD;
				end
				S_FN_RD: state_q <= (j_q > A_2L) ? S_FN_END : S_FN_C;
				S_FN_C: begin
					j_q     <= j_q + s_lvl;
					state_q <= S_FN_M;
				end
				S_FN_M: state_q <= S_FN_RD;
				S_FN_END: begin
					if (stat.fn_ge) begin
						i_q      <= A_L - len1_q;
						k_q      <= '0;
						in_ref_q <= 1'b1;
						state_q  <= S_G_ISS;
					end else begin
						state_q <= S_RF_DON;
					end
				end
				S_RF_NXT: begin
					level_q  <= level_q + LVL_W'(1);
					len1_q   <= len1_q >> 1;
					len2_q   <= len2_q >> 1;
					delta_q  <= delta_q >> 1;
					in_ref_q <= 1'b0;
					state_q  <= S_RF_CHK;
				end
				S_RF_DON: begin
					refine_level_q <= level_q;
					if (more_q) begin
						more_q  <= 1'b0;
						k_q     <= '0;
						state_q <= S_G_ISS;
					end else begin
						em_i_q  <= A_L;
						n_q     <= '0;
						state_q <= S_EM_RD;
					end
				end
				S_EM_RD: state_q <= S_EM_CAP;
				S_EM_CAP: begin
					if (stat.out_free) begin
						if (em_final) begin
							state_q <= S_IDLE;
						end else begin
							em_i_q  <= em_i_q + s_em;
							n_q     <= n_q + CNT_W'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/four_point_curve_subdivider.sv */
// Four-point curve subdivider top level.
// Requests arrive on point_valid/point_stall with action, point_x, point_y; a request is
// taken on a clock edge with point_valid high and point_stall low. Load requests go into
// a five-deep point stage and leave the block free. Start and advance requests set up the
// four-point window in the point buffer, refine the middle segment level by level and
// emit 2^level+1 points on curve_valid/curve_stall, final_point marking the last one.
// Setup copies each window point or computes each rule point in turn; each level runs a
// step scan and, if its largest step reaches the limit, computes its new points in turn;
// emit reads and sends each point. point_stall stays high until the last point sits in
// the output register, so the next request can be taken while that point waits. A stalled
// output register holds its point and the sequencer waits on it. The user must write
// fineness_limit only while idle, through cfg_write_en/cfg_write_data; the block itself
// does not enforce this.
// Reset: lookahead point zero, level one, limit one; buffer and stage are undefined.
module four_point_curve_subdivider #(
	parameter int MAX_LEVEL     = 5,
	parameter int SEGMENT_SPAN  = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_valid,
	output logic               point_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	output logic               curve_valid,
	input  logic               curve_stall,
	output logic signed [31:0] curve_x,
	output logic signed [31:0] curve_y,
	output logic               final_point,
	input  logic               cfg_write_en,
	input  logic [30:0]        cfg_write_data
);
	import fpcs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fpcs_ctrl #(
		.MAX_LEVEL    (MAX_LEVEL),
		.SEGMENT_SPAN (SEGMENT_SPAN)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.action      (action),
		.cmd         (cmd),
		.stat        (stat)
	);

	fpcs_datapath #(
		.SEGMENT_SPAN  (SEGMENT_SPAN),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.action         (action),
		.point_x        (point_x),
		.point_y        (point_y),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.curve_valid    (curve_valid),
		.curve_stall    (curve_stall),
		.curve_x        (curve_x),
		.curve_y        (curve_y),
		.final_point    (final_point)
	);

endmodule

/* sv/fpcs_checker.sv */
// Port-level checker for the four-point curve subdivider, bound to the top level.
module fpcs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               point_valid,
	input logic               point_stall,
	input logic [2:0]         action,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic               curve_valid,
	input logic               curve_stall,
	input logic signed [31:0] curve_x,
	input logic signed [31:0] curve_y,
	input logic               final_point,
	input logic               cfg_write_en,
	input logic [30:0]        cfg_write_data
);
	import fpcs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		curve_valid && curve_stall |=> curve_valid && $stable(curve_x) &&
			$stable(curve_y) && $stable(final_point))
		else $error("stalled curve point changed");

	a_seg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && (action == ACT_OPEN || action == ACT_SIX ||
			action == ACT_ADV || action == ACT_ADV_END) |=> point_stall)
		else $error("segment request did not make the block busy");

	// unknown actions sit above the last defined code
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && (action == ACT_LOAD || action > ACT_ADV_END)
			|=> !point_stall)
		else $error("load or ignored request made the block busy");

endmodule

bind four_point_curve_subdivider fpcs_checker u_fpcs_checker (.*);

/* dv/tb_four_point_curve_subdivider.sv */
// Self-checking testbench for four_point_curve_subdivider: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_four_point_curve_subdivider;
	import fpcs_pkg::*;

	localparam int SPAN = 32;
	localparam int GRID_N = 3 * SPAN + 1;
	localparam int FRACTION_BITS_TB = 8;
	localparam int MAX_LEVEL_TB = 5;
	localparam logic [2:0] ACT_BAD_LO = 3'd5;
	localparam logic [2:0] ACT_BAD_HI = 3'd7;

	typedef struct {
		longint x;
		longint y;
	} cpt_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               last;
	} curve_pt_t;

	typedef struct {
		logic [2:0]  act;
		logic [31:0] x;
		logic [31:0] y;
		bit          lit;
		logic [31:0] lx;
		logic [31:0] ly;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               point_valid;
	logic               point_stall;
	logic [2:0]         action;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic               curve_valid;
	logic               curve_stall;
	logic signed [31:0] curve_x;
	logic signed [31:0] curve_y;
	logic               final_point;
	logic               cfg_write_en;
	logic [30:0]        cfg_write_data;

	// predictor state
	cpt_t      grid[GRID_N];
	cpt_t      stage[5];
	cpt_t      ahead;
	int        seg_level;
	longint    limit_val;
	curve_pt_t curve_due[$];
	int        errors;
	bit        started;

	four_point_curve_subdivider uut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.action(action),
		.point_x(point_x),
		.point_y(point_y),
		.curve_valid(curve_valid),
		.curve_stall(curve_stall),
		.curve_x(curve_x),
		.curve_y(curve_y),
		.final_point(final_point),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint sub1(longint a, longint b, longint c, longint d);
		longint s;
		longint r;
		s = b + c;
		r = s / 2 + (s - a - d) / 16;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	function automatic cpt_t sub4(cpt_t a, cpt_t b, cpt_t c, cpt_t d);
		cpt_t r;
		r.x = sub1(a.x, b.x, c.x, d.x);
		r.y = sub1(a.y, b.y, c.y, d.y);
		return r;
	endfunction

	function automatic int spacing_at(int lv);
		int s;
		s = SPAN >> lv;
		return (s == 0) ? 1 : s;
	endfunction

	// largest Chebyshev step at this level, whole units
	function automatic longint roughness(int lv);
		int     s;
		longint dx;
		longint dy;
		longint m;
		s = spacing_at(lv);
		m = 0;
		for (int i = SPAN; i + s <= 2 * SPAN; i += s) begin
			dx = grid[i].x - grid[i + s].x;
			dy = grid[i].y - grid[i + s].y;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dy > dx) dx = dy;
			dx = dx >> FRACTION_BITS_TB;
			if (dx > m) m = dx;
		end
		return m;
	endfunction

	task automatic refine_segment();
		int len1;
		int len2;
		int delta;
		int lv;
		len1 = SPAN / 4;
		len2 = 3 * len1;
		delta = 2 * len1;
		lv = 1;
		while (lv < MAX_LEVEL_TB && len1 > 0 && delta > 0 && roughness(lv) >= limit_val) begin
			for (int i = SPAN - len1; i <= 2 * SPAN + len1; i += delta)
				grid[i] = sub4(grid[i - len2], grid[i - len1], grid[i + len1], grid[i + len2]);
			lv++;
			len1 >>= 1;
			len2 >>= 1;
			delta >>= 1;
		end
		seg_level = lv;
	endtask

	task automatic queue_segment();
		int        s;
		int        n;
		curve_pt_t p;
		s = spacing_at(seg_level);
		n = 0;
		for (int i = SPAN; i <= 2 * SPAN && n < MAX_OUT; i += s) begin
			p.x = grid[i].x[31:0];
			p.y = grid[i].y[31:0];
			p.last = 1'b0;
			curve_due.push_back(p);
			n++;
		end
		if (n > 0) curve_due[curve_due.size() - 1].last = 1'b1;
	endtask

	task automatic shift_window(bit take_new, cpt_t f);
		grid[0] = grid[SPAN];
		grid[SPAN] = grid[2 * SPAN];
		grid[2 * SPAN] = grid[3 * SPAN];
		grid[3 * SPAN] = ahead;
		if (take_new) ahead = f;
		grid[SPAN / 2] = grid[SPAN / 2 + SPAN];
		grid[SPAN / 2 + SPAN] = grid[SPAN / 2 + 2 * SPAN];
		grid[SPAN / 2 + 2 * SPAN] = sub4(grid[SPAN], grid[2 * SPAN], grid[3 * SPAN], ahead);
	endtask

	task automatic predict_curve(logic [2:0] act, logic signed [31:0] x, logic signed [31:0] y);
		cpt_t f;
		f.x = longint'(x);
		f.y = longint'(y);
		case (act)
			ACT_LOAD: begin
				for (int i = 0; i < 4; i++) stage[i] = stage[i + 1];
				stage[4] = f;
			end
			ACT_OPEN: begin
				ahead = f;
				grid[0] = stage[2];
				grid[SPAN] = stage[2];
				grid[2 * SPAN] = stage[3];
				grid[3 * SPAN] = stage[4];
				grid[SPAN / 2] = sub4(stage[2], stage[2], stage[3], stage[4]);
				grid[SPAN / 2 + SPAN] = grid[SPAN / 2];
				grid[SPAN / 2 + 2 * SPAN] = sub4(stage[2], stage[3], stage[4], f);
				refine_segment();
				// first point duplicated: halves redone for the A,A,B,C window
				grid[SPAN / 2] = sub4(stage[2], stage[2], stage[2], stage[3]);
				grid[SPAN / 2 + SPAN] = sub4(stage[2], stage[2], stage[3], stage[4]);
				grid[SPAN / 2 + 2 * SPAN] = sub4(stage[2], stage[3], stage[4], f);
				refine_segment();
				queue_segment();
			end
			ACT_SIX: begin
				ahead = f;
				grid[0] = stage[1];
				grid[SPAN] = stage[2];
				grid[2 * SPAN] = stage[3];
				grid[3 * SPAN] = stage[4];
				grid[SPAN / 2] = sub4(stage[0], stage[1], stage[2], stage[3]);
				grid[SPAN / 2 + SPAN] = sub4(stage[1], stage[2], stage[3], stage[4]);
				grid[SPAN / 2 + 2 * SPAN] = sub4(stage[2], stage[3], stage[4], f);
				refine_segment();
				queue_segment();
			end
			ACT_ADV: begin
				shift_window(1'b1, f);
				refine_segment();
				queue_segment();
			end
			ACT_ADV_END: begin
				shift_window(1'b0, f);
				refine_segment();
				queue_segment();
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int draw_wait();
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 15);
	endfunction

	// request side: pause, present, hold until taken, then predict
	task automatic send(logic [2:0] act, logic [31:0] x, logic [31:0] y, bit lit = 0,
			logic [31:0] lx = 0, logic [31:0] ly = 0);
		int gap;
		int first;
		gap = draw_wait();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		action <= act;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (point_stall);
		first = curve_due.size();
		predict_curve(act, x, y);
		if (lit && curve_due.size() > first) begin
			curve_due[first].x = lx;
			curve_due[first].y = ly;
		end
	endtask

	task automatic drain();
		point_valid <= 1'b0;
		while (curve_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_limit(logic [30:0] v);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		limit_val = longint'(v);
	endtask

	function automatic logic [31:0] rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 32'($urandom_range(0, 131071)) - 32'd65536;
		if (r < 90) return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			default: return 32'h0;
		endcase
	endfunction

	task automatic random_phase(int n_items);
		int cnt;
		int r;
		cnt = 0;
		while (cnt < n_items) begin
			r = $urandom_range(0, 99);
			if (!started || r < 8) begin
				repeat (5) send(ACT_LOAD, rand_coord(), rand_coord());
				send(($urandom_range(0, 1) != 0) ? ACT_OPEN : ACT_SIX, rand_coord(),
					rand_coord());
				started = 1;
				cnt += 6;
			end else if (r < 13) begin
				send(3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI)), rand_coord(), rand_coord());
			end else if (r < 18) begin
				send(ACT_LOAD, rand_coord(), rand_coord());
				cnt++;
			end else begin
				send(($urandom_range(0, 9) < 7) ? ACT_ADV : ACT_ADV_END, rand_coord(),
					rand_coord());
				cnt++;
			end
		end
	endtask

	// result side
	initial begin
		int        n;
		curve_pt_t want;
		curve_stall = 1'b0;
		forever begin
			n = draw_wait();
			if (n > 0) begin
				curve_stall <= 1'b1;
				repeat (n) @(posedge clk);
				curve_stall <= 1'b0;
			end
			do @(posedge clk); while (!curve_valid);
			if (curve_due.size() == 0) begin
				report("unexpected curve point", curve_x, 32'd0);
			end else begin
				want = curve_due.pop_front();
				if (curve_x !== want.x) report("curve_x", curve_x, want.x);
				if (curve_y !== want.y) report("curve_y", curve_y, want.y);
				if (final_point !== want.last)
					report("final_point", {31'd0, final_point}, {31'd0, want.last});
			end
		end
	end

	initial begin
		#10_000_000;
		$display("four_point_curve_subdivider regression: fail");
		$finish;
	end

	initial begin
		row_t rows[$];
		logic [2:0] bad;
		arst_n = 1'b0;
		point_valid = 1'b0;
		action = ACT_LOAD;
		point_x = '0;
		point_y = '0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		errors = 0;
		started = 0;
		for (int i = 0; i < GRID_N; i++) grid[i] = '{0, 0};
		for (int i = 0; i < 5; i++) stage[i] = '{0, 0};
		ahead = '{0, 0};
		seg_level = 1;
		limit_val = 1;

		bad = ACT_BAD_LO;
		rows = '{
			'{ACT_LOAD, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0},
			'{ACT_LOAD, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0},
			'{ACT_LOAD, 32'h0000_0000, 32'hffff_ffff, 0, 0, 0},
			'{ACT_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0},
			'{ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
			'{ACT_SIX, 32'h0000_1000, 32'hffff_f000, 1, 32'h0, 32'hffff_ffff},
			'{ACT_ADV, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0},
			'{ACT_ADV_END, 32'h0, 32'h0, 0, 0, 0},
			'{bad, 32'h1234_5678, 32'h8765_4321, 0, 0, 0},
			'{bad + 3'd1, 32'hffff_ffff, 32'h0, 0, 0, 0},
			'{ACT_BAD_HI, 32'h0, 32'hffff_ffff, 0, 0, 0},
			'{ACT_LOAD, 32'h0000_0100, 32'h0000_0200, 0, 0, 0},
			'{ACT_LOAD, 32'h0000_0300, 32'hffff_ff00, 0, 0, 0},
			'{ACT_LOAD, 32'h0001_2345, 32'h0005_4321, 0, 0, 0},
			'{ACT_OPEN, 32'h7fff_ffff, 32'h0, 1, 32'h0000_0100, 32'h0000_0200},
			'{ACT_ADV, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0},
			'{ACT_ADV_END, 32'h0, 32'h0, 0, 0, 0},
			'{ACT_ADV_END, 32'h5, 32'h5, 0, 0, 0},
			'{ACT_ADV, 32'h0, 32'h0, 0, 0, 0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send(rows[i].act, rows[i].x, rows[i].y, rows[i].lit, rows[i].lx,
			rows[i].ly);
		started = 1;
		drain();

		set_limit(31'd0);
		random_phase(70);
		drain();
		set_limit(31'h7fff_ffff);
		random_phase(70);
		drain();
		set_limit(31'd1);
		random_phase(70);
		drain();
		set_limit(31'($urandom_range(2, 600)));
		random_phase(70);
		drain();
		set_limit(31'($urandom_range(2, 60)));
		random_phase(70);
		drain();
		set_limit(31'($urandom_range(32'h0010_0000, 32'h7fff_fffe)));
		random_phase(70);
		drain();

		if (errors == 0) begin
			$display("four_point_curve_subdivider regression: pass");
		end else begin
			$display("four_point_curve_subdivider regression: fail");
		end
		$finish;
	end

endmodule
